/* hdl/itrd_pkg.sv */
`timescale 1ns / 1ps

package itrd_pkg;

  localparam int VALUE_W       = 32;
  localparam int RADIX_W       = 5;
  localparam int SYM_W         = 8;
  localparam int SYM_SLOTS     = 16;
  localparam int SYM_IDX_W     = 4;
  localparam int WORD_DIGITS   = 32;
  localparam int DIGIT_IDX_W   = 5;
  localparam int DIV_STEPS     = 8;
  localparam int MAX_RADIX_DEF = 16;
  localparam int CFG_W         = 64;
  localparam int ADDR_W        = 5;

  localparam logic [1:0] REG_RADIX    = 2'd0;
  localparam logic [1:0] REG_SYM_LOW  = 2'd1;
  localparam logic [1:0] REG_SYM_HIGH = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [RADIX_W-1:0] rem;
  } div_out_t;

endpackage

/* hdl/itrd_div.sv */
`timescale 1ns / 1ps

// Restoring divider, DIV_STEPS quotient bits per cycle. Remainder stays below
// the divisor, so each step works on RADIX_W+1 bits.
module itrd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic [itrd_pkg::VALUE_W-1:0]     dividend,
  input  logic [itrd_pkg::RADIX_W-1:0]     divisor,
  output itrd_pkg::div_out_t               result
);

  localparam int ROUNDS = itrd_pkg::VALUE_W / itrd_pkg::DIV_STEPS;
  localparam int CNT_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUNDS - 1);

  logic                           running;
  logic                           done;
  logic [CNT_W-1:0]               cnt;
  logic [itrd_pkg::VALUE_W-1:0]   acc;
  logic [itrd_pkg::RADIX_W-1:0]   rem;
  logic [itrd_pkg::VALUE_W-1:0]   acc_next;
  logic [itrd_pkg::RADIX_W-1:0]   rem_next;

  always_comb begin
    logic [itrd_pkg::RADIX_W:0] trial;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < itrd_pkg::DIV_STEPS; i++) begin
      trial = {rem_next, acc_next[itrd_pkg::VALUE_W-1]};
      if (trial >= {1'b0, divisor}) begin
        rem_next = itrd_pkg::RADIX_W'(trial - {1'b0, divisor});
        acc_next = {acc_next[itrd_pkg::VALUE_W-2:0], 1'b1};
      end else begin
        rem_next = trial[itrd_pkg::RADIX_W-1:0];
        acc_next = {acc_next[itrd_pkg::VALUE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= dividend;
      rem <= '0;
    end else if (running) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign result.done = done;
  assign result.quot = acc;
  assign result.rem  = rem;

endmodule

/* hdl/int_to_radix_digits.sv */
`timescale 1ns / 1ps

// Converts a signed 32-bit value to text in the configured radix, one symbol
// per strobe, most significant digit first, with a leading '-' for negatives;
// last marks the final symbol. Results come as a burst of consecutive strobes
// that the receiver must take as they come. Each of a value's D digits takes one
// pass of the shared 8-bit-per-cycle divider, then the symbols go out one per
// cycle. busy stays high until the last symbol is launched. If the symbol
// table is invalid the value produces no output and busy drops after the
// table check state.
module int_to_radix_digits #(
  parameter int MAX_RADIX = itrd_pkg::MAX_RADIX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [itrd_pkg::VALUE_W-1:0] value,
  output logic                              strobe,
  output logic [itrd_pkg::SYM_W-1:0]        symbol,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [itrd_pkg::ADDR_W-1:0]       paddr,
  input  logic [itrd_pkg::CFG_W-1:0]        pwdata,
  output logic [itrd_pkg::CFG_W-1:0]        prdata,
  output logic                              pready
);

  // remainder < radix <= MAX_RADIX
  localparam int DIG_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_SIGN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [itrd_pkg::RADIX_W-1:0]     radix_in_use;
  logic [itrd_pkg::CFG_W-1:0]       symbols_low;
  logic [itrd_pkg::CFG_W-1:0]       symbols_high;

  logic                             neg;
  logic [itrd_pkg::VALUE_W-1:0]     mag;
  logic [DIG_W-1:0]                 digits [itrd_pkg::WORD_DIGITS];
  logic [itrd_pkg::DIGIT_IDX_W-1:0] cnt;
  logic [itrd_pkg::DIGIT_IDX_W-1:0] ptr;

  logic [2*itrd_pkg::CFG_W-1:0]     sym_flat;
  logic [itrd_pkg::SYM_W-1:0]       sym_arr [itrd_pkg::SYM_SLOTS];
  logic                             table_ok;
  logic                             accept;
  logic                             div_go;
  logic                             div_more;
  logic                             cfg_wr;
  itrd_pkg::div_out_t               div_out;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_in_use <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_wr) begin
      case (paddr[itrd_pkg::ADDR_W-1:3])
        itrd_pkg::REG_RADIX:    radix_in_use <= pwdata[itrd_pkg::RADIX_W-1:0];
        itrd_pkg::REG_SYM_LOW:  symbols_low  <= pwdata;
        itrd_pkg::REG_SYM_HIGH: symbols_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[itrd_pkg::ADDR_W-1:3])
      itrd_pkg::REG_RADIX:
        prdata = {{(itrd_pkg::CFG_W-itrd_pkg::RADIX_W){1'b0}}, radix_in_use};
      itrd_pkg::REG_SYM_LOW:  prdata = symbols_low;
      itrd_pkg::REG_SYM_HIGH: prdata = symbols_high;
      default:                prdata = '0;
    endcase
  end

  assign sym_flat = {symbols_high, symbols_low};

  always_comb begin
    for (int i = 0; i < itrd_pkg::SYM_SLOTS; i++) begin
      sym_arr[i] = sym_flat[i*itrd_pkg::SYM_W +: itrd_pkg::SYM_W];
    end
  end

  // table check: radix range, forbidden symbols, duplicates among used slots
  always_comb begin
    table_ok = (radix_in_use >= itrd_pkg::RADIX_W'(2))
            && (int'(radix_in_use) <= itrd_pkg::SYM_SLOTS)
            && (int'(radix_in_use) <= MAX_RADIX);
    for (int i = 0; i < itrd_pkg::SYM_SLOTS; i++) begin
      if (i < int'(radix_in_use)) begin
        if (sym_arr[i] == '0 || sym_arr[i] == itrd_pkg::CHAR_PLUS ||
            sym_arr[i] == itrd_pkg::CHAR_MINUS) begin
          table_ok = 1'b0;
        end
        for (int j = i + 1; j < itrd_pkg::SYM_SLOTS; j++) begin
          if (j < int'(radix_in_use) && sym_arr[j] == sym_arr[i]) begin
            table_ok = 1'b0;
          end
        end
      end
    end
  end

  assign div_more = (div_out.quot != '0) && (cnt != itrd_pkg::DIGIT_IDX_W'(itrd_pkg::WORD_DIGITS - 1));
  assign div_go   = ((state == S_CHECK) && table_ok)
                 || ((state == S_DIV) && div_out.done && div_more);

  itrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend ((state == S_CHECK) ? mag : div_out.quot),
    .divisor  (radix_in_use),
    .result   (div_out)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CHECK;
      S_CHECK: state_next = table_ok ? S_DIV : S_IDLE;
      S_DIV: begin
        if (div_out.done && !div_more) state_next = neg ? S_SIGN : S_EMIT;
      end
      S_SIGN:  state_next = S_EMIT;
      S_EMIT:  if (ptr == '0) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_SIGN) || (state == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[itrd_pkg::VALUE_W-1];
      mag <= value[itrd_pkg::VALUE_W-1] ? (itrd_pkg::VALUE_W'(0) - value) : value;
    end
    if (state == S_CHECK) begin
      cnt <= '0;
    end
    if (state == S_DIV && div_out.done) begin
      digits[cnt] <= DIG_W'(div_out.rem);
      if (div_more) begin
        cnt <= cnt + 1'b1;
      end else begin
        ptr <= cnt;
      end
    end
    if (state == S_SIGN) begin
      symbol <= itrd_pkg::CHAR_MINUS;
      last   <= 1'b0;
    end
    if (state == S_EMIT) begin
      symbol <= sym_arr[itrd_pkg::SYM_IDX_W'(digits[ptr])];
      last   <= (ptr == '0);
      ptr    <= ptr - 1'b1;
    end
  end

endmodule

/* hdl/itrd_checker.sv */
`timescale 1ns / 1ps

module itrd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       strobe,
  input logic                       last,
  input logic [itrd_pkg::SYM_W-1:0] symbol
);

  // an accepted value keeps the block busy at least for the table check
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted value");

  // a conversion's symbols form one unbroken burst
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside symbol burst");

  // two conversions never run together
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("symbol right after last beat");

  // every symbol is launched while the block is busy
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("symbol without conversion in progress");

  // the sign is never the final symbol
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> symbol != itrd_pkg::CHAR_MINUS)
    else $error("conversion ended on sign");

endmodule

bind int_to_radix_digits itrd_checker u_itrd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .last   (last),
  .symbol (symbol)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import itrd_pkg::*;

  localparam int MAX_RADIX     = MAX_RADIX_DEF;
  localparam int SETTLE_CYCLES = 250;     // settling time after each drain, longer than the longest conversion
  localparam int DRAIN_CAP     = 200000;
  localparam int RAND_PHASES   = 9;
  localparam int RAND_PER_TBL  = 19;
  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped register slot

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [VALUE_W-1:0] value = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;

  logic busy;
  logic strobe;
  logic [SYM_W-1:0] symbol;
  logic last;
  logic [CFG_W-1:0] prdata;
  logic pready;

  // local copy of the configuration
  logic [RADIX_W-1:0] cfg_radix = '0;
  logic [CFG_W-1:0]   cfg_sym_lo = '0;
  logic [CFG_W-1:0]   cfg_sym_hi = '0;

  logic [VALUE_W-1:0] pending_values[$];
  char_beat_t         expected_chars[$];
  char_beat_t         head_char;
  int                 idle_pct = 0;
  int                 mismatches = 0;
  int                 items_sent = 0;
  int                 beats_checked = 0;
  int                 tables_loaded = 0;

  int_to_radix_digits #(.MAX_RADIX(MAX_RADIX)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value),
    .strobe(strobe), .symbol(symbol), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  function automatic logic [SYM_W-1:0] digit_symbol(int d);
    logic [2*CFG_W-1:0] tbl;
    tbl = {cfg_sym_hi, cfg_sym_lo};
    return tbl[8*d +: 8];
  endfunction

  function automatic bit table_valid();
    logic [SYM_W-1:0] s;
    if (cfg_radix < 2 || cfg_radix > MAX_RADIX || cfg_radix > SYM_SLOTS) return 1'b0;
    for (int i = 0; i < cfg_radix; i++) begin
      s = digit_symbol(i);
      if (s == '0 || s == CHAR_PLUS || s == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < cfg_radix; j++)
        if (digit_symbol(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the symbol beats one accepted value should produce
  task automatic predict_text(logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    int digits[WORD_DIGITS];
    int nd;
    bit neg;
    nd = 0;
    if (!table_valid()) return;
    base = VALUE_W'(cfg_radix);
    neg = raw[VALUE_W-1];
    mag = neg ? (32'd0 - raw) : raw;
    do begin
      digits[nd] = int'(mag % base);
      mag = mag / base;
      nd++;
    end while (mag != 0 && nd < WORD_DIGITS);
    if (neg) expected_chars.push_back('{symbol: CHAR_MINUS, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      expected_chars.push_back('{symbol: digit_symbol(digits[k]), last: (k == 0)});
  endtask

  // driver: a beat is taken at an edge with start high and busy low
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_text(value);
        items_sent++;
        if (pending_values.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          value <= pending_values.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_values.size() > 0 &&
                   $urandom_range(0, 99) >= idle_pct) begin
        value <= pending_values.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat symbol=%h last=%b", symbol, last));
      end else begin
        head_char = expected_chars.pop_front();
        beats_checked++;
        if (symbol !== head_char.symbol || last !== head_char.last)
          report_mismatch($sformatf("symbol exp %h got %h, last exp %b got %b",
                                    head_char.symbol, symbol, head_char.last, last));
      end
    end
  end

  task automatic apb_read(logic [1:0] idx, output logic [CFG_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(logic [1:0] idx, logic [CFG_W-1:0] data);
    logic [CFG_W-1:0] rd;
    logic [CFG_W-1:0] mask;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RADIX:    cfg_radix = data[RADIX_W-1:0];
      REG_SYM_LOW:  cfg_sym_lo = data;
      REG_SYM_HIGH: cfg_sym_hi = data;
      default: ;
    endcase
    if (idx != REG_SPARE) begin
      apb_read(idx, rd);
      mask = (idx == REG_RADIX) ? CFG_W'({RADIX_W{1'b1}}) : '1;
      if ((rd & mask) !== (data & mask))
        report_mismatch($sformatf("reg %0d readback exp %h got %h", idx, data & mask,
                                  rd & mask));
    end
  endtask

  task automatic set_table(logic [RADIX_W-1:0] r, logic [CFG_W-1:0] lo,
                           logic [CFG_W-1:0] hi);
    apb_write(REG_RADIX, CFG_W'(r));
    apb_write(REG_SYM_LOW, lo);
    apb_write(REG_SYM_HIGH, hi);
    tables_loaded++;
  endtask

  // distinct legal symbols in use, junk in the unused slots
  task automatic pick_valid_table(int r, output logic [CFG_W-1:0] lo,
                                  output logic [CFG_W-1:0] hi);
    logic [2*CFG_W-1:0] t;
    bit used[256];
    int s;
    for (int i = 0; i < 256; i++) used[i] = 1'b0;
    for (int i = 0; i < SYM_SLOTS; i++) begin
      if (i < r) begin
        do s = $urandom_range(1, 255);
        while (used[s] || s == int'(CHAR_PLUS) || s == int'(CHAR_MINUS));
        used[s] = 1'b1;
        t[8*i +: 8] = s[7:0];
      end else begin
        t[8*i +: 8] = 8'($urandom_range(0, 255));
      end
    end
    lo = t[CFG_W-1:0];
    hi = t[2*CFG_W-1:CFG_W];
  endtask

  function automatic logic [VALUE_W-1:0] rand_value(int r);
    int span;
    span = r * r * r;
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return VALUE_W'($urandom_range(0, span));
      3:       return 32'd0 - VALUE_W'($urandom_range(1, span));
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // wait until all queued beats are out and the block is quiet
  task automatic drain();
    int waited;
    waited = 0;
    while (!(pending_values.size() == 0 && !start && expected_chars.size() == 0 && !busy)
           && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", expected_chars.size()));
      expected_chars.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int idle_mix[4];
    logic [CFG_W-1:0] dec_lo, dec_hi, hex_lo, hex_hi, lo, hi;
    int r;
    idle_mix = '{0, 68, 0, 29};
    dec_lo = 64'h3736_3534_3332_3130;   // "01234567"
    dec_hi = 64'h4645_4443_4241_3938;   // "89ABCDEF"
    hex_lo = dec_lo;
    hex_hi = dec_hi;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // table invalid out of reset
    pending_values.push_back(32'd42);
    pending_values.push_back(32'h8000_0000);
    drain();

    // decimal
    set_table(5'd10, dec_lo, {48'h0, dec_hi[15:0]});
    idle_pct = 68;
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(32'hFFFF_FFF6);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    drain();
    // write to the unmapped slot must leave the table alone
    apb_write(REG_SPARE, {$urandom, $urandom});
    pending_values.push_back(32'd123456789);
    pending_values.push_back(32'hC521_974F);
    drain();

    // binary, the longest text
    set_table(5'd2, 64'h3130, 64'h0);
    idle_pct = 0;
    pending_values.push_back(32'd0);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'd5);
    drain();

    // hex, full table
    set_table(5'd16, hex_lo, hex_hi);
    idle_pct = 29;
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'hDEAD_BEEF);
    pending_values.push_back(32'd15);
    pending_values.push_back(32'd16);
    drain();

    // invalid tables: radix too small, too large, zero, plus, minus, repeated symbol
    set_table(5'd1, dec_lo, dec_hi);
    pending_values.push_back(32'd7);
    drain();
    set_table(5'd31, dec_lo, dec_hi);
    pending_values.push_back(32'hFFFF_FFFF);
    drain();
    set_table(5'd17, dec_lo, dec_hi);
    pending_values.push_back(32'd17);
    drain();
    set_table(5'd10, {dec_lo[63:48], 8'h00, dec_lo[39:0]}, dec_hi);
    pending_values.push_back(32'd55);
    drain();
    set_table(5'd10, {dec_lo[63:8], CHAR_PLUS}, dec_hi);
    pending_values.push_back(32'd3);
    drain();
    set_table(5'd16, hex_lo, {CHAR_MINUS, hex_hi[55:0]});
    pending_values.push_back(32'd255);
    drain();
    set_table(5'd10, {dec_lo[63:32], 8'h39, dec_lo[23:0]}, dec_hi);
    pending_values.push_back(32'd99);
    drain();

    // random legal tables, radix extremes first
    for (int p = 0; p < RAND_PHASES; p++) begin
      r = (p == 0) ? 2 : (p == 1) ? 16 : $urandom_range(2, 16);
      pick_valid_table(r, lo, hi);
      set_table(5'(r), lo, hi);
      idle_pct = idle_mix[p % 4];
      repeat (RAND_PER_TBL) pending_values.push_back(rand_value(r));
      drain();
    end

    // raw register contents, mostly rejected
    for (int p = 0; p < 3; p++) begin
      set_table(5'($urandom_range(0, 31)), {$urandom, $urandom}, {$urandom, $urandom});
      idle_pct = idle_mix[p % 4];
      repeat (4) pending_values.push_back($urandom);
      drain();
    end

    $display("Converted %0d values under %0d symbol tables, %0d symbol beats checked",
             items_sent, tables_loaded, beats_checked);
    $display("Covered radix 2 to 16, rejected tables and the most negative value");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d beats outstanding", expected_chars.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
